/* design/lrz_pkg.sv */
package lrz_pkg;

    // Fixed field widths on the ports
    localparam int IN_COORD_W  = 16;
    localparam int OUT_COORD_W = 9;
    localparam int COLOR_W     = 16;
    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 4 * IN_COORD_W + COLOR_W;
    localparam int OUT_DATA_W  = 56;

    // Register values after reset
    localparam int SCREEN_W_RST = 240;
    localparam int SCREEN_H_RST = 320;

    typedef logic [OUT_COORD_W-1:0] out_coord_t;
    typedef logic [IN_COORD_W-1:0]  in_coord_t;
    typedef logic [COLOR_W-1:0]     color_t;
    typedef logic [CFG_W-1:0]       cfg_data_t;

    typedef enum logic [0:0]
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_index_t;

    // Per-item strobes from the pipeline control to the line state
    typedef struct packed
    {
        logic start;
        logic step;
    } line_ctl_t;

endpackage

/* design/lrz_cfg.sv */
module lrz_cfg #(
    parameter int MAX_SIDE = 512,
    parameter int CW       = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  lrz_pkg::cfg_data_t   wr_data,
    output logic [CW-1:0]        col_lim,
    output logic [CW-1:0]        row_lim
);
    import lrz_pkg::*;

    logic [CW-1:0] col_lim_reg;
    logic [CW-1:0] row_lim_reg;

    // Largest legal coordinate for a side size; zero acts as one,
    // anything above MAX_SIDE acts as MAX_SIDE
    function automatic logic [CW-1:0] side_lim(input cfg_data_t v);
        logic [CW-1:0] r;
        if (v == '0)
        begin
            r = '0;
        end
        else if (32'(v) > MAX_SIDE)
        begin
            r = CW'(MAX_SIDE - 1);
        end
        else
        begin
            r = CW'(v - 10'd1);
        end
        return r;
    endfunction

    // Limits are kept pre-reduced so the clamp sees a plain bound
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_lim_reg <= side_lim(CFG_W'(SCREEN_W_RST));
            row_lim_reg <= side_lim(CFG_W'(SCREEN_H_RST));
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_SCREEN_WIDTH:  col_lim_reg <= side_lim(wr_data);
                REG_SCREEN_HEIGHT: row_lim_reg <= side_lim(wr_data);
                default:           col_lim_reg <= col_lim_reg;
            endcase
        end
    end

    assign col_lim = col_lim_reg;
    assign row_lim = row_lim_reg;

endmodule

/* design/lrz_setup.sv */
module lrz_setup #(
    parameter int CW = 9,
    parameter int EW = 11
) (
    input  lrz_pkg::in_coord_t   x_first,
    input  lrz_pkg::in_coord_t   y_first,
    input  lrz_pkg::in_coord_t   x_final,
    input  lrz_pkg::in_coord_t   y_final,
    input  logic [CW-1:0]        col_lim,
    input  logic [CW-1:0]        row_lim,
    output logic [CW-1:0]        col0,
    output logic [CW-1:0]        row0,
    output logic [CW-1:0]        col1,
    output logic [CW-1:0]        row1,
    output logic [CW-1:0]        dist_col,
    output logic [CW-1:0]        dist_row,
    output logic                 dir_left,
    output logic                 dir_up,
    output logic                 straight,
    output logic signed [EW-1:0] err_init
);
    import lrz_pkg::*;

    // Clamp to the screen
    assign col0 = (x_first > IN_COORD_W'(col_lim)) ? col_lim : CW'(x_first);
    assign row0 = (y_first > IN_COORD_W'(row_lim)) ? row_lim : CW'(y_first);
    assign col1 = (x_final > IN_COORD_W'(col_lim)) ? col_lim : CW'(x_final);
    assign row1 = (y_final > IN_COORD_W'(row_lim)) ? row_lim : CW'(y_final);

    // Direction and absolute distances
    assign dir_left = col0 > col1;
    assign dir_up   = row0 > row1;
    assign dist_col = dir_left ? (col0 - col1) : (col1 - col0);
    assign dist_row = dir_up   ? (row0 - row1) : (row1 - row0);
    assign straight = (dist_col == '0) || (dist_row == '0);

    // Half the major distance, negative when rows dominate or the distances are equal
    always_comb
    begin
        if (dist_col > dist_row)
        begin
            err_init = $signed(EW'(dist_col >> 1));
        end
        else
        begin
            err_init = -$signed(EW'(dist_row >> 1));
        end
    end

endmodule

/* design/lrz_line.sv */
module lrz_line #(
    parameter int CW = 9,
    parameter int EW = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrz_pkg::line_ctl_t   ctl,
    input  logic [CW-1:0]        col0,
    input  logic [CW-1:0]        row0,
    input  logic [CW-1:0]        col1,
    input  logic [CW-1:0]        row1,
    input  logic [CW-1:0]        dist_col,
    input  logic [CW-1:0]        dist_row,
    input  logic                 dir_left,
    input  logic                 dir_up,
    input  logic                 straight,
    input  logic signed [EW-1:0] err_init,
    input  lrz_pkg::color_t      in_color,
    output logic                 busy,
    output logic                 res_valid,
    output logic [CW-1:0]        res_col_lo,
    output logic [CW-1:0]        res_row_lo,
    output logic [CW-1:0]        res_col_hi,
    output logic [CW-1:0]        res_row_hi,
    output lrz_pkg::color_t      res_color,
    output logic                 res_last
);
    import lrz_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [CW-1:0]        cur_col_reg;
    logic [CW-1:0]        cur_row_reg;
    logic [CW-1:0]        end_col_reg;
    logic [CW-1:0]        end_row_reg;
    logic [CW-1:0]        dist_col_reg;
    logic [CW-1:0]        dist_row_reg;
    logic                 dir_left_reg;
    logic                 dir_up_reg;
    logic signed [EW-1:0] err_reg;
    color_t               color_reg;

    logic signed [EW-1:0] dc_s;
    logic signed [EW-1:0] dr_s;
    logic                 mv_col;
    logic                 mv_row;
    logic signed [EW-1:0] err_step;
    logic [CW-1:0]        col_step;
    logic [CW-1:0]        row_step;
    logic                 done;

    // One Bresenham step from the stored line state
    assign dc_s   = $signed(EW'(dist_col_reg));
    assign dr_s   = $signed(EW'(dist_row_reg));
    assign mv_col = err_reg > -dc_s;
    assign mv_row = err_reg < dr_s;

    always_comb
    begin
        err_step = err_reg;
        col_step = cur_col_reg;
        row_step = cur_row_reg;
        if (mv_col)
        begin
            err_step = err_step - dr_s;
            col_step = dir_left_reg ? (cur_col_reg - 1'b1) : (cur_col_reg + 1'b1);
        end
        if (mv_row)
        begin
            err_step = err_step + dc_s;
            row_step = dir_up_reg ? (cur_row_reg - 1'b1) : (cur_row_reg + 1'b1);
        end
    end

    assign done = (col_step == end_col_reg) && (row_step == end_row_reg);

    // Busy flag: a start drops any running line
    always_comb
    begin
        busy_next = busy_reg;
        if (ctl.start)
        begin
            busy_next = !straight;
        end
        else if (ctl.step && busy_reg && done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Line state
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cur_col_reg  <= col0;
            cur_row_reg  <= row0;
            end_col_reg  <= col1;
            end_row_reg  <= row1;
            dist_col_reg <= dist_col;
            dist_row_reg <= dist_row;
            dir_left_reg <= dir_left;
            dir_up_reg   <= dir_up;
            color_reg    <= in_color;
            if (!straight)
            begin
                err_reg <= err_init;
            end
        end
        else if (ctl.step && busy_reg)
        begin
            cur_col_reg <= col_step;
            cur_row_reg <= row_step;
            err_reg     <= err_step;
        end
    end

    // Result of the current item
    always_comb
    begin
        res_valid  = ctl.start || (ctl.step && busy_reg);
        res_color  = color_reg;
        res_col_lo = col_step;
        res_row_lo = row_step;
        res_col_hi = col_step;
        res_row_hi = row_step;
        res_last   = done;
        if (ctl.start)
        begin
            res_color = in_color;
            res_last  = straight;
            if (straight)
            begin
                res_col_lo = dir_left ? col1 : col0;
                res_col_hi = dir_left ? col0 : col1;
                res_row_lo = dir_up ? row1 : row0;
                res_row_hi = dir_up ? row0 : row1;
            end
            else
            begin
                res_col_lo = col0;
                res_col_hi = col0;
                res_row_lo = row0;
                res_row_hi = row0;
            end
        end
    end

    assign busy = busy_reg;

endmodule

/* design/clamped_line_rasterizer_unit.sv */
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser opcode, tdata end points and colour
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata window and colour, tlast end of line
// cfg       in   cfg_wr_en                     cfg_wr_index, cfg_wr_data (no read-back)
//
// One item per cycle sustained while the output is not stalled.
// Input register, one pass of clamp / setup / Bresenham step logic, result register.
// A step transfer while no line is running is consumed and gives no result.
// Output stall back-pressures the input register; both sides hold a transfer each.
// rst_n is asynchronous: idle, screen size 240 x 320.
module clamped_line_rasterizer_unit #(
    parameter int MAX_SIDE = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_first, y_first, x_final, y_final, pixel_color
    input  logic [lrz_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // col_low, row_low, col_high, row_high, color_out, zero pad
    output logic [lrz_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last
    output logic                          m_axis_tlast,
    input  logic                          cfg_wr_en,
    input  logic [lrz_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [lrz_pkg::CFG_W-1:0]     cfg_wr_data
);
    import lrz_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int EW = CW + 2;

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    opcode_t    op_reg;
    in_coord_t  x_first_reg;
    in_coord_t  y_first_reg;
    in_coord_t  x_final_reg;
    in_coord_t  y_final_reg;
    color_t     color_in_reg;

    // Result register
    logic       out_valid_reg;
    logic       out_valid_next;
    out_coord_t col_lo_reg;
    out_coord_t row_lo_reg;
    out_coord_t col_hi_reg;
    out_coord_t row_hi_reg;
    color_t     color_out_reg;
    logic       last_reg;

    logic       fire;
    logic       s_xfer;
    line_ctl_t  ctl;

    logic [CW-1:0]        col_lim;
    logic [CW-1:0]        row_lim;
    logic [CW-1:0]        col0;
    logic [CW-1:0]        row0;
    logic [CW-1:0]        col1;
    logic [CW-1:0]        row1;
    logic [CW-1:0]        dist_col;
    logic [CW-1:0]        dist_row;
    logic                 dir_left;
    logic                 dir_up;
    logic                 straight;
    logic signed [EW-1:0] err_init;
    logic                 busy;
    logic                 res_valid;
    logic [CW-1:0]        res_col_lo;
    logic [CW-1:0]        res_row_lo;
    logic [CW-1:0]        res_col_hi;
    logic [CW-1:0]        res_row_hi;
    color_t               res_color;
    logic                 res_last;

    // Pipeline control
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign ctl.start     = fire && (op_reg == OP_START);
    assign ctl.step      = fire && (op_reg == OP_STEP);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload capture
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            op_reg       <= opcode_t'(s_axis_tuser);
            x_first_reg  <= s_axis_tdata[0*IN_COORD_W +: IN_COORD_W];
            y_first_reg  <= s_axis_tdata[1*IN_COORD_W +: IN_COORD_W];
            x_final_reg  <= s_axis_tdata[2*IN_COORD_W +: IN_COORD_W];
            y_final_reg  <= s_axis_tdata[3*IN_COORD_W +: IN_COORD_W];
            color_in_reg <= s_axis_tdata[4*IN_COORD_W +: COLOR_W];
        end
    end

    // Result payload capture
    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            col_lo_reg    <= out_coord_t'(res_col_lo);
            row_lo_reg    <= out_coord_t'(res_row_lo);
            col_hi_reg    <= out_coord_t'(res_col_hi);
            row_hi_reg    <= out_coord_t'(res_row_hi);
            color_out_reg <= res_color;
            last_reg      <= res_last;
        end
    end

    lrz_cfg #(
        .MAX_SIDE (MAX_SIDE),
        .CW       (CW)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_wr_index),
        .wr_data  (cfg_wr_data),
        .col_lim  (col_lim),
        .row_lim  (row_lim)
    );

    lrz_setup #(
        .CW (CW),
        .EW (EW)
    ) u_setup (
        .x_first  (x_first_reg),
        .y_first  (y_first_reg),
        .x_final  (x_final_reg),
        .y_final  (y_final_reg),
        .col_lim  (col_lim),
        .row_lim  (row_lim),
        .col0     (col0),
        .row0     (row0),
        .col1     (col1),
        .row1     (row1),
        .dist_col (dist_col),
        .dist_row (dist_row),
        .dir_left (dir_left),
        .dir_up   (dir_up),
        .straight (straight),
        .err_init (err_init)
    );

    lrz_line #(
        .CW (CW),
        .EW (EW)
    ) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .col0       (col0),
        .row0       (row0),
        .col1       (col1),
        .row1       (row1),
        .dist_col   (dist_col),
        .dist_row   (dist_row),
        .dir_left   (dir_left),
        .dir_up     (dir_up),
        .straight   (straight),
        .err_init   (err_init),
        .in_color   (color_in_reg),
        .busy       (busy),
        .res_valid  (res_valid),
        .res_col_lo (res_col_lo),
        .res_row_lo (res_row_lo),
        .res_col_hi (res_col_hi),
        .res_row_hi (res_row_hi),
        .res_color  (res_color),
        .res_last   (res_last)
    );

    // Output channel
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = OUT_DATA_W'({color_out_reg, row_hi_reg, col_hi_reg,
                                        row_lo_reg, col_lo_reg});

`ifndef SYNTH
    // A start always produces a result
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> m_axis_tvalid)
        else $error("start transfer gave no result");

    // A step with no running line is swallowed
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && !busy) |=> !m_axis_tvalid)
        else $error("step while idle gave a result");

    // Input back-pressure only while the input register is occupied
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // Only the final result of a line may be a wider window
    a_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (col_lo_reg == col_hi_reg) && (row_lo_reg == row_hi_reg))
        else $error("non-final result is not a single pixel");
`endif

endmodule
